// File: sv/tbw_pkg.sv
// Shared constants and types for the triangle barycentric weights core.
package tbw_pkg;

    // Width of each saturated weight on the result channel
    localparam int OUT_BITS = 24;

    // Entries in the queue between the front and back parts
    localparam int QUEUE_DEPTH = 4;

    // Queue fill status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// File: sv/tbw_mul.sv
// Two-stage signed multiplier built from four half-width partial products.
module tbw_mul #(
    parameter int W = 36
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic signed [W-1:0]   i_a,
    input  logic signed [W-1:0]   i_b,
    output logic signed [2*W-1:0] o_p
);

    localparam int H  = W / 2;
    localparam int HW = W - H;

    logic signed [HW-1:0]   a_hi;
    logic signed [HW-1:0]   b_hi;
    logic signed [H:0]      a_lo;
    logic signed [H:0]      b_lo;

    logic signed [2*HW-1:0] r_hh;
    logic signed [W:0]      r_hl;
    logic signed [W:0]      r_lh;
    logic [2*H-1:0]         r_ll;
    logic signed [2*W-1:0]  r_p;

    // Split operands: signed upper half, unsigned lower half
    assign a_hi = i_a[W-1:H];
    assign b_hi = i_b[W-1:H];
    assign a_lo = $signed({1'b0, i_a[H-1:0]});
    assign b_lo = $signed({1'b0, i_b[H-1:0]});

    // Partial products, then weighted sum
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hh <= a_hi * b_hi;
            r_hl <= a_hi * b_lo;
            r_lh <= a_lo * b_hi;
            r_ll <= i_a[H-1:0] * i_b[H-1:0];
            r_p  <= ((2*W)'(r_hh) <<< (2*H)) + ((2*W)'(r_hl) <<< H)
                  + ((2*W)'(r_lh) <<< H) + $signed((2*W)'(r_ll));
        end
    end

    assign o_p = r_p;

endmodule

// File: sv/tbw_front.sv
// Front part: edge vectors, Gram entries, determinant and Cramer numerators.
module tbw_front #(
    parameter int COORD_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic signed [COORD_BITS-1:0] i_query_x,
    input  logic signed [COORD_BITS-1:0] i_query_y,
    input  logic signed [COORD_BITS-1:0] i_query_z,
    input  logic signed [COORD_BITS-1:0] i_corner_a_x,
    input  logic signed [COORD_BITS-1:0] i_corner_a_y,
    input  logic signed [COORD_BITS-1:0] i_corner_a_z,
    input  logic signed [COORD_BITS-1:0] i_corner_b_x,
    input  logic signed [COORD_BITS-1:0] i_corner_b_y,
    input  logic signed [COORD_BITS-1:0] i_corner_b_z,
    input  logic signed [COORD_BITS-1:0] i_corner_c_x,
    input  logic signed [COORD_BITS-1:0] i_corner_c_y,
    input  logic signed [COORD_BITS-1:0] i_corner_c_z,
    input  tbw_pkg::t_q_status           i_q,
    output logic                        o_push,
    output logic [3*(4*COORD_BITS+9):0]  o_push_data
);

    localparam int DW   = COORD_BITS + 1;
    localparam int PW   = 2 * DW;
    localparam int DOTW = PW + 2;
    localparam int GW   = 2 * DOTW;
    localparam int DETW = GW + 1;

    logic                         en_f;
    logic [5:0]                   r_v;

    logic signed [COORD_BITS-1:0] cq[3];
    logic signed [COORD_BITS-1:0] ca[3];
    logic signed [COORD_BITS-1:0] cb[3];
    logic signed [COORD_BITS-1:0] cc[3];

    logic signed [DW-1:0]   r_du[3];
    logic signed [DW-1:0]   r_dv[3];
    logic signed [DW-1:0]   r_dw[3];
    logic signed [PW-1:0]   r_puu[3];
    logic signed [PW-1:0]   r_puv[3];
    logic signed [PW-1:0]   r_pvv[3];
    logic signed [PW-1:0]   r_puw[3];
    logic signed [PW-1:0]   r_pvw[3];
    logic signed [DOTW-1:0] r_uu;
    logic signed [DOTW-1:0] r_uv;
    logic signed [DOTW-1:0] r_vv;
    logic signed [DOTW-1:0] r_uw;
    logic signed [DOTW-1:0] r_vw;
    logic signed [GW-1:0]   p_uuvv;
    logic signed [GW-1:0]   p_uvuv;
    logic signed [GW-1:0]   p_uwvv;
    logic signed [GW-1:0]   p_uvvw;
    logic signed [GW-1:0]   p_uuvw;
    logic signed [GW-1:0]   p_uwuv;
    logic signed [DETW-1:0] det;
    logic signed [DETW-1:0] r_det;
    logic signed [DETW-1:0] r_n0;
    logic signed [DETW-1:0] r_n1;
    logic                   r_degen;

    // The pipe moves unless the last stage holds an item the queue cannot take
    assign en_f       = !(r_v[5] && i_q.full);
    assign o_in_stall = !en_f;
    assign o_push     = r_v[5] && !i_q.full;
    assign o_push_data = {r_degen, r_det, r_n0, r_n1};

    assign cq = '{i_query_x, i_query_y, i_query_z};
    assign ca = '{i_corner_a_x, i_corner_a_y, i_corner_a_z};
    assign cb = '{i_corner_b_x, i_corner_b_y, i_corner_b_z};
    assign cc = '{i_corner_c_x, i_corner_c_y, i_corner_c_z};

    // Valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en_f) begin
            r_v <= {r_v[4:0], i_in_valid};
        end
    end

    // Edge differences from the third corner, then per-axis products
    always_ff @(posedge i_clk) begin
        if (en_f) begin
            for (int k = 0; k < 3; k++) begin
                r_du[k]  <= DW'(ca[k]) - DW'(cc[k]);
                r_dv[k]  <= DW'(cb[k]) - DW'(cc[k]);
                r_dw[k]  <= DW'(cq[k]) - DW'(cc[k]);
                r_puu[k] <= r_du[k] * r_du[k];
                r_puv[k] <= r_du[k] * r_dv[k];
                r_pvv[k] <= r_dv[k] * r_dv[k];
                r_puw[k] <= r_du[k] * r_dw[k];
                r_pvw[k] <= r_dv[k] * r_dw[k];
            end
        end
    end

    // Gram entries
    always_ff @(posedge i_clk) begin
        if (en_f) begin
            r_uu <= DOTW'(r_puu[0]) + DOTW'(r_puu[1]) + DOTW'(r_puu[2]);
            r_uv <= DOTW'(r_puv[0]) + DOTW'(r_puv[1]) + DOTW'(r_puv[2]);
            r_vv <= DOTW'(r_pvv[0]) + DOTW'(r_pvv[1]) + DOTW'(r_pvv[2]);
            r_uw <= DOTW'(r_puw[0]) + DOTW'(r_puw[1]) + DOTW'(r_puw[2]);
            r_vw <= DOTW'(r_pvw[0]) + DOTW'(r_pvw[1]) + DOTW'(r_pvw[2]);
        end
    end

    // Second-order products, two stages each
    tbw_mul #(.W(DOTW)) u_mul_uuvv (
        .i_clk(i_clk), .i_en(en_f), .i_a(r_uu), .i_b(r_vv), .o_p(p_uuvv)
    );
    tbw_mul #(.W(DOTW)) u_mul_uvuv (
        .i_clk(i_clk), .i_en(en_f), .i_a(r_uv), .i_b(r_uv), .o_p(p_uvuv)
    );
    tbw_mul #(.W(DOTW)) u_mul_uwvv (
        .i_clk(i_clk), .i_en(en_f), .i_a(r_uw), .i_b(r_vv), .o_p(p_uwvv)
    );
    tbw_mul #(.W(DOTW)) u_mul_uvvw (
        .i_clk(i_clk), .i_en(en_f), .i_a(r_uv), .i_b(r_vw), .o_p(p_uvvw)
    );
    tbw_mul #(.W(DOTW)) u_mul_uuvw (
        .i_clk(i_clk), .i_en(en_f), .i_a(r_uu), .i_b(r_vw), .o_p(p_uuvw)
    );
    tbw_mul #(.W(DOTW)) u_mul_uwuv (
        .i_clk(i_clk), .i_en(en_f), .i_a(r_uw), .i_b(r_uv), .o_p(p_uwuv)
    );

    // Determinant, numerators and the collapsed-triangle flag
    assign det = DETW'(p_uuvv) - DETW'(p_uvuv);

    always_ff @(posedge i_clk) begin
        if (en_f) begin
            r_det   <= det;
            r_n0    <= DETW'(p_uwvv) - DETW'(p_uvvw);
            r_n1    <= DETW'(p_uuvw) - DETW'(p_uwuv);
            r_degen <= (det == '0);
        end
    end

endmodule

// File: sv/tbw_queue.sv
// Small FIFO between the front and back parts.
module tbw_queue #(
    parameter int W = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  logic [W-1:0]        i_data,
    input  logic                i_pop,
    output logic [W-1:0]        o_data,
    output tbw_pkg::t_q_status  o_q
);

    localparam int AW = $clog2(tbw_pkg::QUEUE_DEPTH);
    localparam int CW = $clog2(tbw_pkg::QUEUE_DEPTH + 1);

    logic [W-1:0]  r_mem[tbw_pkg::QUEUE_DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_cnt;

    assign o_data   = r_mem[r_rd];
    assign o_q.full  = (r_cnt == CW'(tbw_pkg::QUEUE_DEPTH));
    assign o_q.empty = (r_cnt == '0);

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(tbw_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(tbw_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// File: sv/tbw_back.sv
// Back part: pipelined restoring dividers, third weight, saturation, output register.
module tbw_back #(
    parameter int COORD_BITS       = 16,
    parameter int WEIGHT_FRAC_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  tbw_pkg::t_q_status                   i_q,
    output logic                                 o_pop,
    input  logic [3*(4*COORD_BITS+9):0]          i_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [tbw_pkg::OUT_BITS-1:0]  o_weight_a,
    output logic signed [tbw_pkg::OUT_BITS-1:0]  o_weight_b,
    output logic signed [tbw_pkg::OUT_BITS-1:0]  o_weight_c,
    output logic                                 o_degenerate
);

    localparam int DETW = 4 * COORD_BITS + 9;
    localparam int NW   = DETW + WEIGHT_FRAC_BITS;
    localparam int SW   = NW + 1;
    localparam int XW   = NW + 3;
    localparam int OB   = tbw_pkg::OUT_BITS;
    localparam logic signed [XW-1:0] SMAX = XW'((2**(OB-1)) - 1);
    localparam logic signed [XW-1:0] SMIN = -SMAX - XW'(1);

    logic                   en_b;
    logic                   q_degen;
    logic signed [DETW-1:0] q_det;
    logic signed [DETW-1:0] q_n0;
    logic signed [DETW-1:0] q_n1;
    logic signed [NW-1:0]   n0s;
    logic signed [NW-1:0]   n1s;

    // Divider pipe: index k holds the item after k quotient steps
    logic                   r_dv[NW+1];
    logic                   r_dg[NW+1];
    logic                   r_s0[NW+1];
    logic                   r_s1[NW+1];
    logic [DETW-1:0]        r_d[NW+1];
    logic [DETW-1:0]        r_rem0[NW+1];
    logic [DETW-1:0]        r_rem1[NW+1];
    logic [NW-1:0]          r_nq0[NW+1];
    logic [NW-1:0]          r_nq1[NW+1];

    logic                   r_vs;
    logic                   r_gs;
    logic signed [SW-1:0]   r_wa;
    logic signed [SW-1:0]   r_wb;
    logic                   r_vt;
    logic                   r_gt;
    logic signed [XW-1:0]   r_xa;
    logic signed [XW-1:0]   r_xb;
    logic signed [XW-1:0]   r_xc;

    logic                   r_out_valid;
    logic signed [OB-1:0]   r_weight_a;
    logic signed [OB-1:0]   r_weight_b;
    logic signed [OB-1:0]   r_weight_c;
    logic                   r_degenerate;

    function automatic logic signed [OB-1:0] sat(input logic signed [XW-1:0] v);
        logic signed [XW-1:0] t;
        t = (v > SMAX) ? SMAX : ((v < SMIN) ? SMIN : v);
        return t[OB-1:0];
    endfunction

    // Whole back pipe advances when the output register is free or being taken
    assign en_b  = !(r_out_valid && i_out_stall);
    assign o_pop = en_b && !i_q.empty;

    assign {q_degen, q_det, q_n0, q_n1} = i_data;
    assign n0s = NW'(q_n0) <<< WEIGHT_FRAC_BITS;
    assign n1s = NW'(q_n1) <<< WEIGHT_FRAC_BITS;

    // Entry: magnitudes and quotient signs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else if (en_b) begin
            r_dv[0] <= !i_q.empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_b) begin
            r_dg[0]   <= q_degen;
            r_s0[0]   <= q_n0[DETW-1] ^ q_det[DETW-1];
            r_s1[0]   <= q_n1[DETW-1] ^ q_det[DETW-1];
            r_d[0]    <= q_det[DETW-1] ? DETW'(-q_det) : q_det;
            r_rem0[0] <= '0;
            r_rem1[0] <= '0;
            r_nq0[0]  <= n0s[NW-1] ? NW'(-n0s) : n0s;
            r_nq1[0]  <= n1s[NW-1] ? NW'(-n1s) : n1s;
        end
    end

    // One quotient bit per stage for both numerators
    for (genvar k = 0; k < NW; k++) begin : g_div
        logic [DETW:0] t0;
        logic [DETW:0] t1;
        logic [DETW:0] df0;
        logic [DETW:0] df1;
        logic          ge0;
        logic          ge1;

        assign t0  = {r_rem0[k], r_nq0[k][NW-1]};
        assign t1  = {r_rem1[k], r_nq1[k][NW-1]};
        assign ge0 = (t0 >= {1'b0, r_d[k]});
        assign ge1 = (t1 >= {1'b0, r_d[k]});
        assign df0 = t0 - {1'b0, r_d[k]};
        assign df1 = t1 - {1'b0, r_d[k]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[k+1] <= 1'b0;
            end else if (en_b) begin
                r_dv[k+1] <= r_dv[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en_b) begin
                r_dg[k+1]   <= r_dg[k];
                r_s0[k+1]   <= r_s0[k];
                r_s1[k+1]   <= r_s1[k];
                r_d[k+1]    <= r_d[k];
                r_rem0[k+1] <= ge0 ? df0[DETW-1:0] : t0[DETW-1:0];
                r_rem1[k+1] <= ge1 ? df1[DETW-1:0] : t1[DETW-1:0];
                r_nq0[k+1]  <= {r_nq0[k][NW-2:0], ge0};
                r_nq1[k+1]  <= {r_nq1[k][NW-2:0], ge1};
            end
        end
    end

    // Signed quotients, then third weight, then saturation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vs        <= 1'b0;
            r_vt        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en_b) begin
            r_vs        <= r_dv[NW];
            r_vt        <= r_vs;
            r_out_valid <= r_vt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_b) begin
            r_gs <= r_dg[NW];
            r_wa <= r_s0[NW] ? -$signed({1'b0, r_nq0[NW]}) : $signed({1'b0, r_nq0[NW]});
            r_wb <= r_s1[NW] ? -$signed({1'b0, r_nq1[NW]}) : $signed({1'b0, r_nq1[NW]});
            r_gt <= r_gs;
            r_xa <= XW'(r_wa);
            r_xb <= XW'(r_wb);
            r_xc <= (XW'(1) <<< WEIGHT_FRAC_BITS) - XW'(r_wa) - XW'(r_wb);
            r_degenerate <= r_gt;
            r_weight_a   <= r_gt ? '0 : sat(r_xa);
            r_weight_b   <= r_gt ? '0 : sat(r_xb);
            r_weight_c   <= r_gt ? '0 : sat(r_xc);
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_weight_a   = r_weight_a;
    assign o_weight_b   = r_weight_b;
    assign o_weight_c   = r_weight_c;
    assign o_degenerate = r_degenerate;

endmodule

// File: sv/triangle_barycentric_weights_core.sv
// Most of the path from input accept to result lies in the back part's divider, which
// forms one quotient bit per stage.
// Throughput: one item per cycle unless a full queue or i_out_stall holds it; front
// and back move independently around a four-entry queue; a stalled result holds the back.
// Reset: synchronous, active low; clears all valid flags, queue pointers and count.
module triangle_barycentric_weights_core #(
    parameter int COORD_BITS       = 16,
    parameter int WEIGHT_FRAC_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic signed [COORD_BITS-1:0]         i_query_x,
    input  logic signed [COORD_BITS-1:0]         i_query_y,
    input  logic signed [COORD_BITS-1:0]         i_query_z,
    input  logic signed [COORD_BITS-1:0]         i_corner_a_x,
    input  logic signed [COORD_BITS-1:0]         i_corner_a_y,
    input  logic signed [COORD_BITS-1:0]         i_corner_a_z,
    input  logic signed [COORD_BITS-1:0]         i_corner_b_x,
    input  logic signed [COORD_BITS-1:0]         i_corner_b_y,
    input  logic signed [COORD_BITS-1:0]         i_corner_b_z,
    input  logic signed [COORD_BITS-1:0]         i_corner_c_x,
    input  logic signed [COORD_BITS-1:0]         i_corner_c_y,
    input  logic signed [COORD_BITS-1:0]         i_corner_c_z,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [tbw_pkg::OUT_BITS-1:0]  o_weight_a,
    output logic signed [tbw_pkg::OUT_BITS-1:0]  o_weight_b,
    output logic signed [tbw_pkg::OUT_BITS-1:0]  o_weight_c,
    output logic                                 o_degenerate
);

    localparam int QW = 3 * (4 * COORD_BITS + 9) + 1;

    logic               push;
    logic               pop;
    logic [QW-1:0]      push_data;
    logic [QW-1:0]      pop_data;
    tbw_pkg::t_q_status q_status;

    // Gram matrix and numerators
    tbw_front #(.COORD_BITS(COORD_BITS)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_query_x    (i_query_x),
        .i_query_y    (i_query_y),
        .i_query_z    (i_query_z),
        .i_corner_a_x (i_corner_a_x),
        .i_corner_a_y (i_corner_a_y),
        .i_corner_a_z (i_corner_a_z),
        .i_corner_b_x (i_corner_b_x),
        .i_corner_b_y (i_corner_b_y),
        .i_corner_b_z (i_corner_b_z),
        .i_corner_c_x (i_corner_c_x),
        .i_corner_c_y (i_corner_c_y),
        .i_corner_c_z (i_corner_c_z),
        .i_q          (q_status),
        .o_push       (push),
        .o_push_data  (push_data)
    );

    // Decoupling queue
    tbw_queue #(.W(QW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .i_pop   (pop),
        .o_data  (pop_data),
        .o_q     (q_status)
    );

    // Division and result formatting
    tbw_back #(
        .COORD_BITS       (COORD_BITS),
        .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q          (q_status),
        .o_pop        (pop),
        .i_data       (pop_data),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_weight_a   (o_weight_a),
        .o_weight_b   (o_weight_b),
        .o_weight_c   (o_weight_c),
        .o_degenerate (o_degenerate)
    );

endmodule
